### design/assert_macros.svh
// Assertion macros for the FLV tag index parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at each rising clock edge outside reset.
`define FLVP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flvp assertion failed");

// Next-cycle implication, checked at each rising clock edge outside reset.
`define FLVP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flvp assertion failed");

`else

`define FLVP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define FLVP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### design/flvp_pkg.sv
package flvp_pkg;

    // Width of the internal byte position counter; positions wrap at this width.
    localparam int POS_W = 32;

    localparam int TAG_HDR_LEN = 1 + 4 + 3 + 3 + 1 + 4;

    localparam logic [1:0] KIND_VIDEO   = 2'd0;
    localparam logic [1:0] KIND_AUDIO   = 2'd1;
    localparam logic [1:0] KIND_BAD_SIG = 2'd2;
    localparam logic [1:0] KIND_BAD_TAG = 2'd3;

    localparam logic [7:0] TAG_AUDIO = 8'd8;
    localparam logic [7:0] TAG_VIDEO = 8'd9;
    localparam logic [3:0] CODEC_VP6 = 4'd4;
    localparam logic [3:0] FMT_NELLY_8K = 4'd5;

    localparam logic [15:0] RATE_44K = 16'd44100;
    localparam logic [15:0] RATE_22K = 16'd22050;
    localparam logic [15:0] RATE_11K = 16'd11025;
    localparam logic [15:0] RATE_8K  = 16'd8000;
    localparam logic [15:0] RATE_5K  = 16'd5512;

    localparam logic [11:0] DEFAULT_WIDTH  = 12'd320;
    localparam logic [11:0] DEFAULT_HEIGHT = 12'd240;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] payload_position;
        logic [23:0] payload_length;
        logic [23:0] timestamp_ms;
        logic        key_frame;
        logic [3:0]  codec_id;
        logic        first_in_track;
        logic [15:0] sample_rate_hz;
        logic [1:0]  channel_count;
        logic [4:0]  sample_bits;
        logic [11:0] frame_width;
        logic [11:0] frame_height;
    } t_out_item;

    typedef struct packed {
        logic [15:0] rate;
        logic [1:0]  channels;
        logic [4:0]  bits;
    } t_audio_fmt;

    // File signature: 'F' 'L' 'V'
    function automatic logic [7:0] sig_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = 8'h46;
            2'd1:    v = 8'h4C;
            default: v = 8'h56;
        endcase
        return v;
    endfunction

endpackage

### design/flvp_audio_dec.sv
module flvp_audio_dec (
    input  logic [7:0]          i_flag_byte,
    output flvp_pkg::t_audio_fmt o_fmt
);
    import flvp_pkg::*;

    logic [3:0] fmt;
    logic [1:0] rate_code;

    assign fmt       = i_flag_byte[7:4];
    assign rate_code = i_flag_byte[3:2];

    always_comb begin
        unique case (rate_code)
            2'd3:    o_fmt.rate = RATE_44K;
            2'd2:    o_fmt.rate = RATE_22K;
            2'd1:    o_fmt.rate = RATE_11K;
            default: o_fmt.rate = (fmt == FMT_NELLY_8K) ? RATE_8K : RATE_5K;
        endcase
        o_fmt.channels = 2'(i_flag_byte[0]) + 2'd1;
        o_fmt.bits     = i_flag_byte[1] ? 5'd16 : 5'd8;
    end

endmodule

### design/flv_tag_index_parser_core.sv
// FLV tag index parser.
// Input channel: one byte of an FLV file per item (i_in_valid / o_in_stall,
// payload i_in_item). Set file_start on byte 0 of every file; it restarts the
// parse. Bytes before the first file_start, and after an error, are dropped.
// Output channel: at most one index entry or error per input byte
// (o_out_valid / i_out_stall, payload o_out_item). Audio and video tags give
// entries; a bad signature or a tag too short for its headers gives an error
// and the parser then waits for the next file_start.
// An accepted byte is held in the input register, parsed combinationally, and its
// result is captured in the result register, which drives o_out_valid.
// Throughput: one byte per cycle while the receiver does not stall; the parse
// step between the input register and the result register is combinational.
// When the receiver stalls, the pending result holds and one more byte is
// taken into the input register; o_in_stall then rises until the result
// drains. Synchronous reset clears all parse state and both channels.
`include "assert_macros.svh"

module flv_tag_index_parser_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  flvp_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output flvp_pkg::t_out_item o_out_item
);
    import flvp_pkg::*;

    typedef enum logic [3:0] {
        PH_WAIT, PH_HEAD, PH_SKIP, PH_TAGH, PH_AFLAG,
        PH_VFLAG, PH_VEXTRA, PH_VP6, PH_BODY
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [3:0]       r_fcnt, n_fcnt;
    logic [31:0]      r_acc, n_acc;
    logic [7:0]       r_tag_kind, n_tag_kind;
    logic [23:0]      r_size, n_size;
    logic [23:0]      r_ts, n_ts;
    logic [POS_W-1:0] r_tag_start, n_tag_start;
    logic [23:0]      r_left, n_left;
    logic [7:0]       r_flags, n_flags;
    logic [POS_W-1:0] r_offset, n_offset;
    logic             r_vseen, n_vseen;
    logic             r_aseen, n_aseen;
    logic [7:0]       r_vp6h, n_vp6h;

    t_in_item         r_in;
    logic             r_in_valid, n_in_valid;
    t_out_item        r_out, n_out;
    logic             r_out_valid, n_out_valid;

    logic             in_accept;
    logic             proc_fire;
    logic [7:0]       b;
    logic [POS_W-1:0] cur;
    logic [3:0]       hdr_n;
    logic             do_tagh;
    logic             do_video;
    logic             v_extra;
    logic [11:0]      v_w;
    logic [11:0]      v_h;
    logic             v_first;
    logic             vp6;
    logic [2:0]       need;
    t_audio_fmt       afmt;

    assign b          = r_in.data_byte;
    assign proc_fire  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    flvp_audio_dec u_audio_dec (
        .i_flag_byte (b),
        .o_fmt       (afmt)
    );

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_fcnt      = r_fcnt;
        n_acc       = r_acc;
        n_tag_kind  = r_tag_kind;
        n_size      = r_size;
        n_ts        = r_ts;
        n_tag_start = r_tag_start;
        n_left      = r_left;
        n_flags     = r_flags;
        n_offset    = r_offset;
        n_vseen     = r_vseen;
        n_aseen     = r_aseen;
        n_vp6h      = r_vp6h;
        n_out       = r_out;
        cur         = '0;
        hdr_n       = '0;
        do_tagh     = 1'b0;
        do_video    = 1'b0;
        v_extra     = 1'b0;
        v_w         = '0;
        v_h         = '0;
        v_first     = 1'b0;
        vp6         = 1'b0;
        need        = '0;

        n_in_valid  = in_accept ? 1'b1 : (proc_fire ? 1'b0 : r_in_valid);
        n_out_valid = (r_out_valid && i_out_stall) ? 1'b1 : 1'b0;

        if (proc_fire) begin
            n_out_valid = 1'b0;
            n_out       = '0;
            if (r_in.file_start) begin
                n_phase     = PH_HEAD;
                n_pos       = '0;
                n_fcnt      = '0;
                n_acc       = '0;
                n_tag_kind  = '0;
                n_size      = '0;
                n_ts        = '0;
                n_tag_start = '0;
                n_left      = '0;
                n_flags     = '0;
                n_offset    = '0;
                n_vseen     = 1'b0;
                n_aseen     = 1'b0;
                n_vp6h      = '0;
            end
            if (n_phase != PH_WAIT) begin
                cur   = n_pos;
                n_pos = cur + POS_W'(1);
                unique case (n_phase)
                    PH_HEAD: begin
                        if (cur < POS_W'(3)) begin
                            if (b != sig_byte(cur[1:0])) begin
                                n_phase             = PH_WAIT;
                                n_out_valid         = 1'b1;
                                n_out.result_kind   = KIND_BAD_SIG;
                            end
                        end else if (cur == POS_W'(4)) begin
                            n_flags = b;
                        end else if (cur >= POS_W'(5)) begin
                            n_acc = {n_acc[23:0], b};
                            if (cur == POS_W'(8)) begin
                                n_offset = POS_W'(n_acc);
                                if (n_offset < POS_W'(9)) begin
                                    n_offset = POS_W'(9);
                                end
                                n_phase = PH_SKIP;
                            end
                        end
                    end
                    PH_SKIP: begin
                        if (cur == n_offset) begin
                            n_phase = PH_TAGH;
                            n_fcnt  = '0;
                            do_tagh = 1'b1;
                        end
                    end
                    PH_TAGH: begin
                        do_tagh = 1'b1;
                    end
                    PH_AFLAG: begin
                        v_first = !n_aseen;
                        n_flags = b;
                        n_aseen = 1'b1;
                        n_left  = n_size - 24'd1;
                        n_phase = (n_left != '0) ? PH_BODY : PH_TAGH;
                        n_fcnt  = '0;
                        n_out_valid            = 1'b1;
                        n_out.result_kind      = KIND_AUDIO;
                        n_out.payload_position = 32'(n_tag_start + POS_W'(TAG_HDR_LEN));
                        n_out.payload_length   = n_left;
                        n_out.timestamp_ms     = n_ts;
                        n_out.codec_id         = b[7:4];
                        n_out.first_in_track   = v_first;
                        if (v_first) begin
                            n_out.sample_rate_hz = afmt.rate;
                            n_out.channel_count  = afmt.channels;
                            n_out.sample_bits    = afmt.bits;
                        end
                    end
                    PH_VFLAG: begin
                        vp6     = (b[3:0] == CODEC_VP6);
                        need    = vp6 ? (n_vseen ? 3'd2 : 3'd6) : 3'd1;
                        n_flags = b;
                        if (n_size < 24'(need)) begin
                            n_phase           = PH_WAIT;
                            n_out_valid       = 1'b1;
                            n_out.result_kind = KIND_BAD_TAG;
                        end else if (vp6) begin
                            n_phase = PH_VEXTRA;
                        end else begin
                            n_left   = n_size - 24'd1;
                            n_phase  = (n_left != '0) ? PH_BODY : PH_TAGH;
                            n_fcnt   = '0;
                            do_video = 1'b1;
                            v_w      = DEFAULT_WIDTH;
                            v_h      = DEFAULT_HEIGHT;
                        end
                    end
                    PH_VEXTRA: begin
                        if (!n_vseen) begin
                            n_phase = PH_VP6;
                            n_fcnt  = '0;
                        end else begin
                            n_left   = n_size - 24'd2;
                            n_phase  = (n_left != '0) ? PH_BODY : PH_TAGH;
                            n_fcnt   = '0;
                            do_video = 1'b1;
                            v_extra  = 1'b1;
                        end
                    end
                    PH_VP6: begin
                        hdr_n  = n_fcnt;
                        n_fcnt = hdr_n + 4'd1;
                        if (hdr_n == 4'd2) begin
                            n_vp6h = b;
                        end
                        if (hdr_n >= 4'd3) begin
                            n_left   = n_size - 24'd6;
                            n_phase  = (n_left != '0) ? PH_BODY : PH_TAGH;
                            n_fcnt   = '0;
                            do_video = 1'b1;
                            v_extra  = 1'b1;
                            v_w      = {b, 4'b0000};
                            v_h      = {n_vp6h, 4'b0000};
                        end
                    end
                    PH_BODY: begin
                        n_left = n_left - 24'd1;
                        if (n_left == '0) begin
                            n_phase = PH_TAGH;
                            n_fcnt  = '0;
                        end
                    end
                    default: begin
                        n_phase = PH_WAIT;
                    end
                endcase

                // Tag header: prev size, type, size, timestamp, ext + stream id
                if (do_tagh) begin
                    hdr_n  = n_fcnt;
                    n_fcnt = hdr_n + 4'd1;
                    if (hdr_n == 4'd0) begin
                        n_tag_start = cur;
                    end
                    if (hdr_n == 4'd4) begin
                        n_tag_kind = b;
                    end else if (hdr_n >= 4'd5 && hdr_n <= 4'd7) begin
                        n_size = {n_size[15:0], b};
                    end else if (hdr_n >= 4'd8 && hdr_n <= 4'd10) begin
                        n_ts = {n_ts[15:0], b};
                    end else if (hdr_n == 4'd14) begin
                        n_fcnt = '0;
                        if (n_tag_kind == TAG_AUDIO || n_tag_kind == TAG_VIDEO) begin
                            if (n_size == '0) begin
                                n_phase           = PH_WAIT;
                                n_out_valid       = 1'b1;
                                n_out.result_kind = KIND_BAD_TAG;
                            end else begin
                                n_phase = (n_tag_kind == TAG_AUDIO) ? PH_AFLAG : PH_VFLAG;
                            end
                        end else begin
                            n_left  = n_size;
                            n_phase = (n_size != '0) ? PH_BODY : PH_TAGH;
                        end
                    end
                end

                if (do_video) begin
                    v_first                = !n_vseen;
                    n_vseen                = 1'b1;
                    n_out_valid            = 1'b1;
                    n_out.result_kind      = KIND_VIDEO;
                    n_out.payload_position = 32'(n_tag_start + POS_W'(TAG_HDR_LEN)
                                                 + POS_W'(v_extra));
                    n_out.payload_length   = n_size - 24'd1 - 24'(v_extra);
                    n_out.timestamp_ms     = n_ts;
                    n_out.key_frame        = (n_flags[7:4] == 4'd1) || v_first;
                    n_out.codec_id         = n_flags[3:0];
                    n_out.first_in_track   = v_first;
                    if (v_first) begin
                        n_out.frame_width  = v_w;
                        n_out.frame_height = v_h;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WAIT;
            r_pos       <= '0;
            r_fcnt      <= '0;
            r_acc       <= '0;
            r_tag_kind  <= '0;
            r_size      <= '0;
            r_ts        <= '0;
            r_tag_start <= '0;
            r_left      <= '0;
            r_flags     <= '0;
            r_offset    <= '0;
            r_vseen     <= 1'b0;
            r_aseen     <= 1'b0;
            r_vp6h      <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_fcnt      <= n_fcnt;
            r_acc       <= n_acc;
            r_tag_kind  <= n_tag_kind;
            r_size      <= n_size;
            r_ts        <= n_ts;
            r_tag_start <= n_tag_start;
            r_left      <= n_left;
            r_flags     <= n_flags;
            r_offset    <= n_offset;
            r_vseen     <= n_vseen;
            r_aseen     <= n_aseen;
            r_vp6h      <= n_vp6h;
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
        if (in_accept) begin
            r_in <= i_in_item;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `FLVP_ASSERT_IMPLY(a_error_clean, i_clk, i_rst_n,
        r_out_valid && (r_out.result_kind == KIND_BAD_SIG || r_out.result_kind == KIND_BAD_TAG),
        r_out.payload_position == '0 && r_out.payload_length == '0)
    `FLVP_ASSERT_IMPLY(a_first_audio_fmt, i_clk, i_rst_n,
        r_out_valid && r_out.result_kind == KIND_AUDIO && r_out.first_in_track,
        r_out.sample_rate_hz != '0 && r_out.channel_count != '0)
    `FLVP_ASSERT_IMPLY(a_later_video_nosize, i_clk, i_rst_n,
        r_out_valid && r_out.result_kind == KIND_VIDEO && !r_out.first_in_track,
        r_out.frame_width == '0 && r_out.frame_height == '0)
    `FLVP_ASSERT_NEXT(a_wait_silent, i_clk, i_rst_n,
        proc_fire && r_phase == PH_WAIT && !r_in.file_start,
        !r_out_valid)

endmodule
